FILE: rtl/vt4_pkg.sv
// Package with payload types and configuration constants for the vertex transform.
`default_nettype none
package vt4_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NUM_COEF_REGS = 8;
    localparam int CFG_IDX_W     = 3;

    typedef enum logic [1:0] {
        KIND_FULL4   = 2'd0,
        KIND_PROJ3   = 2'd1,
        KIND_AFFINE  = 2'd2,
        KIND_ROT3    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]   kind;
        logic [31:0]  vec_x;
        logic [31:0]  vec_y;
        logic [31:0]  vec_z;
        logic [31:0]  vec_w;
    } vt4_in_t;

    typedef struct packed {
        logic [31:0]  out_x;
        logic [31:0]  out_y;
        logic [31:0]  out_z;
        logic [31:0]  out_w;
        logic         divide_by_zero;
        logic         saturated;
    } vt4_out_t;

    localparam logic [63:0] COEF_RESET [NUM_COEF_REGS] = '{
        64'd65536, 64'd0, 64'd281474976710656, 64'd0,
        64'd0, 64'd65536, 64'd0, 64'd281474976710656
    };

endpackage
`default_nettype wire

FILE: rtl/vertex_transform_4x4.sv
// Top level of the pipelined homogeneous 4x4 vertex transform.
// One vector is accepted every cycle while the result side does not stall, and its result passes
// through the same stages in every mode. The depth is set by the stages of the
// mode 1 restoring divider (one quotient bit per stage for each of x, y and z, over the 67-bit
// numerator magnitude and FRAC_BITS fraction bits), while the 16 row products take one
// multiplier stage, the row sums two adder stages and the quotient saturation one output stage. All stages
// advance together on a global enable, so a stall on the result side holds every stage,
// and nothing is lost or repeated.
`default_nettype none
module vertex_transform_4x4 #(
    parameter int FRAC_BITS = vt4_pkg::FRAC_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire vt4_pkg::vt4_in_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output vt4_pkg::vt4_out_t                  out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [vt4_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [63:0]                   cfg_value
);
    // Quotient before the fraction loop must stay below 2^(32-FRAC_BITS); the numerator
    // after truncation fits in 68 bits signed.
    localparam int NW        = 68;   // numerator/denominator width (signed)
    localparam int MW        = 67;   // magnitude width
    localparam int QW        = 34;

    logic [63:0] coef_reg [vt4_pkg::NUM_COEF_REGS];
    logic        adv;

    assign adv       = ~out_valid | out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < vt4_pkg::NUM_COEF_REGS; i++)
            begin
                coef_reg[i] <= vt4_pkg::COEF_RESET[i];
            end
        end
        else if (cfg_valid)
        begin
            coef_reg[cfg_index] <= cfg_value;
        end
    end

    function automatic logic signed [31:0] elem(input int e, input logic [63:0] c [8]);
        logic [63:0] r;
        r = c[e / 2];
        return (e % 2 == 1) ? r[63:32] : r[31:0];
    endfunction

    // Stage 1: operand select and the 16 products.
    logic               s1_v_reg;
    logic [1:0]         s1_kind_reg;
    logic signed [63:0] s1_p_reg [4][4];
    logic signed [32:0] vsel [4];

    always_comb
    begin
        vsel[0] = 33'(signed'(in_data.vec_x));
        vsel[1] = 33'(signed'(in_data.vec_y));
        vsel[2] = 33'(signed'(in_data.vec_z));
        case (in_data.kind)
            vt4_pkg::KIND_FULL4: vsel[3] = 33'(signed'(in_data.vec_w));
            vt4_pkg::KIND_ROT3:  vsel[3] = '0;
            default:             vsel[3] = 33'(1) <<< FRAC_BITS;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_kind_reg <= in_data.kind;
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    s1_p_reg[r][c] <= 64'(elem(c * 4 + r, coef_reg)) * 64'(vsel[c]);
                end
            end
        end
    end

    // Stage 2: pairwise sums.
    logic               s2_v_reg;
    logic [1:0]         s2_kind_reg;
    logic signed [64:0] s2_s_reg [4][2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_kind_reg <= s1_kind_reg;
            for (int r = 0; r < 4; r++)
            begin
                s2_s_reg[r][0] <= 65'(s1_p_reg[r][0]) + 65'(s1_p_reg[r][1]);
                s2_s_reg[r][1] <= 65'(s1_p_reg[r][2]) + 65'(s1_p_reg[r][3]);
            end
        end
    end

    // Stage 3: row totals, floored to the fixed-point grid.
    logic               s3_v_reg;
    logic [1:0]         s3_kind_reg;
    logic signed [NW-1:0] s3_row_reg [4];
    logic signed [65:0] tot [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            tot[r] = 66'(s2_s_reg[r][0]) + 66'(s2_s_reg[r][1]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            s3_v_reg <= s2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_kind_reg <= s2_kind_reg;
            for (int r = 0; r < 4; r++)
            begin
                s3_row_reg[r] <= NW'(tot[r] >>> FRAC_BITS);
            end
        end
    end

    // Stage 4: saturate the direct results, prepare magnitudes and signs for the divider.
    typedef struct packed {
        logic [1:0]      kind;
        logic            dz;
        logic            sat;
        logic [31:0]     dir_x;
        logic [31:0]     dir_y;
        logic [31:0]     dir_z;
        logic [31:0]     dir_w;
        logic [2:0]      neg;
        logic [MW-1:0]   den;
    } side_t;

    function automatic logic [32:0] sat32(input logic signed [NW-1:0] v);
        // Bit 32 flags a clamp.
        if (v > NW'(64'sd2147483647))
        begin
            return {1'b1, 32'h7fff_ffff};
        end
        else if (v < -NW'(64'sd2147483648))
        begin
            return {1'b1, 32'h8000_0000};
        end
        return {1'b0, v[31:0]};
    endfunction

    localparam int NST = MW + FRAC_BITS;  // divider stages
    localparam int RW  = MW + 1;

    logic          d_v_reg   [NST+1];
    side_t         d_sd_reg  [NST+1];
    logic [RW-1:0] d_r_reg   [NST+1][3];
    logic [MW-1:0] d_n_reg   [NST+1][3]; // numerator bits still to shift in
    logic [QW-1:0] d_q_reg   [NST+1][3];

    side_t       sd0;
    logic [32:0] st [4];
    logic [MW-1:0] mag [4];

    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            st[r]  = sat32(s3_row_reg[r]);
            mag[r] = s3_row_reg[r][NW-1] ? MW'(-s3_row_reg[r]) : MW'(s3_row_reg[r]);
        end
        sd0.kind  = s3_kind_reg;
        sd0.dz    = (s3_kind_reg == vt4_pkg::KIND_PROJ3) && (s3_row_reg[3] == '0);
        sd0.dir_x = st[0][31:0];
        sd0.dir_y = st[1][31:0];
        sd0.dir_z = st[2][31:0];
        sd0.dir_w = (s3_kind_reg == vt4_pkg::KIND_FULL4) ? st[3][31:0] : '0;
        sd0.sat   = st[0][32] | st[1][32] | st[2][32] |
                    ((s3_kind_reg == vt4_pkg::KIND_FULL4) & st[3][32]);
        for (int r = 0; r < 3; r++)
        begin
            sd0.neg[r] = s3_row_reg[r][NW-1] ^ s3_row_reg[3][NW-1];
        end
        sd0.den = mag[3];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NST; i++)
            begin
                d_v_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            d_v_reg[0] <= s3_v_reg;
            for (int i = 1; i <= NST; i++)
            begin
                d_v_reg[i] <= d_v_reg[i-1];
            end
        end
    end

    // Restoring divider: one stage per quotient bit; numerator bits first, then zeros for
    // the fractional part. The quotient keeps its low QW bits plus a sticky overflow.
    logic [RW-1:0] trial [NST][3];
    logic [RW-1:0] rsh   [NST][3];
    always_comb
    begin
        for (int i = 0; i < NST; i++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                rsh[i][k]   = {d_r_reg[i][k][RW-2:0], d_n_reg[i][k][MW-1]};
                trial[i][k] = rsh[i][k] - RW'(d_sd_reg[i].den);
            end
        end
    end

    logic [2:0] ovf_reg [NST+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_sd_reg[0] <= sd0;
            ovf_reg[0]  <= '0;
            for (int k = 0; k < 3; k++)
            begin
                d_r_reg[0][k] <= '0;
                d_n_reg[0][k] <= mag[k];
                d_q_reg[0][k] <= '0;
            end
            for (int i = 0; i < NST; i++)
            begin
                d_sd_reg[i+1] <= d_sd_reg[i];
                for (int k = 0; k < 3; k++)
                begin
                    d_n_reg[i+1][k] <= {d_n_reg[i][k][MW-2:0], 1'b0};
                    if (!trial[i][k][RW-1])
                    begin
                        d_r_reg[i+1][k] <= trial[i][k];
                        d_q_reg[i+1][k] <= {d_q_reg[i][k][QW-2:0], 1'b1};
                    end
                    else
                    begin
                        d_r_reg[i+1][k] <= rsh[i][k];
                        d_q_reg[i+1][k] <= {d_q_reg[i][k][QW-2:0], 1'b0};
                    end
                    ovf_reg[i+1][k] <= ovf_reg[i][k] | d_q_reg[i][k][QW-1];
                end
            end
        end
    end

    // Output stage.
    side_t         sdf;
    logic [31:0]   qres [3];
    logic [2:0]    qsat;
    always_comb
    begin
        sdf = d_sd_reg[NST];
        for (int k = 0; k < 3; k++)
        begin
            if (ovf_reg[NST][k] || d_q_reg[NST][k][QW-1:31] != '0 &&
                !(sdf.neg[k] && d_q_reg[NST][k] == QW'(34'h0_8000_0000)))
            begin
                qsat[k] = 1'b1;
                qres[k] = sdf.neg[k] ? 32'h8000_0000 : 32'h7fff_ffff;
            end
            else
            begin
                qsat[k] = 1'b0;
                qres[k] = sdf.neg[k] ? 32'(-d_q_reg[NST][k]) : d_q_reg[NST][k][31:0];
            end
        end
    end

    vt4_pkg::vt4_out_t res_next;
    always_comb
    begin
        res_next = '0;
        if (sdf.kind == vt4_pkg::KIND_PROJ3)
        begin
            if (sdf.dz)
            begin
                res_next.divide_by_zero = 1'b1;
            end
            else
            begin
                res_next.out_x     = qres[0];
                res_next.out_y     = qres[1];
                res_next.out_z     = qres[2];
                res_next.saturated = |qsat;
            end
        end
        else
        begin
            res_next.out_x     = sdf.dir_x;
            res_next.out_y     = sdf.dir_y;
            res_next.out_z     = sdf.dir_z;
            res_next.out_w     = sdf.dir_w;
            res_next.saturated = sdf.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (adv)
        begin
            out_valid <= d_v_reg[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data <= res_next;
        end
    end

endmodule
`default_nettype wire

FILE: test/tb_vertex_transform_4x4.sv
// Self-checking testbench for the 4x4 vertex transform: directed table, then random vectors.
`default_nettype none
module tb_vertex_transform_4x4;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FB = vt4_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 71 + FB + 10;
    localparam int N_RANDOM = 1800;

    typedef struct {
        vt4_pkg::vt4_in_t  vec;
        bit                has_expect;
        vt4_pkg::vt4_out_t expect_out;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    vt4_pkg::vt4_in_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    vt4_pkg::vt4_out_t out_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [vt4_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0] cfg_value = '0;

    logic [63:0] matrix_regs [vt4_pkg::NUM_COEF_REGS];
    vt4_pkg::vt4_out_t pending_vectors [$];
    int error_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    vertex_transform_4x4 dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_value(cfg_value)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint coef(int e);
        logic [63:0] r;
        r = matrix_regs[e / 2];
        return (e % 2) ? longint'(signed'(r[63:32])) : longint'(signed'(r[31:0]));
    endfunction

    // Exact row sum, floored to FB fractional bits; 128-bit arithmetic avoids overflow.
    function automatic logic signed [127:0] row_sum(int row, longint v [4]);
        logic signed [127:0] acc;
        acc = 0;
        for (int c = 0; c < 4; c++)
            acc += 128'(signed'(coef(c * 4 + row))) * 128'(signed'(v[c]));
        return acc >>> FB;
    endfunction

    function automatic logic [31:0] clamp32(logic signed [127:0] v, inout bit sat);
        if (v > 128'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] scaled_quotient(logic signed [127:0] n,
                                                    logic signed [127:0] d, inout bit sat);
        logic [127:0] un;
        logic [127:0] ud;
        logic [127:0] q;
        bit neg;
        neg = (n < 0) != (d < 0);
        un = (n < 0) ? -n : n;
        ud = (d < 0) ? -d : d;
        q = (un << FB) / ud;
        return clamp32(neg ? -$signed(q) : $signed(q), sat);
    endfunction

    function automatic vt4_pkg::vt4_out_t transform_vector(vt4_pkg::vt4_in_t t);
        longint v [4];
        vt4_pkg::vt4_out_t r;
        bit sat;
        logic signed [127:0] den;
        sat = 1'b0;
        r = '0;
        v[0] = longint'(signed'(t.vec_x));
        v[1] = longint'(signed'(t.vec_y));
        v[2] = longint'(signed'(t.vec_z));
        case (vt4_pkg::kind_t'(t.kind))
            vt4_pkg::KIND_FULL4: v[3] = longint'(signed'(t.vec_w));
            vt4_pkg::KIND_ROT3:  v[3] = 0;
            default:             v[3] = longint'(1) << FB;
        endcase
        if (vt4_pkg::kind_t'(t.kind) == vt4_pkg::KIND_PROJ3)
        begin
            den = row_sum(3, v);
            if (den == 0)
                r.divide_by_zero = 1'b1;
            else
            begin
                r.out_x = scaled_quotient(row_sum(0, v), den, sat);
                r.out_y = scaled_quotient(row_sum(1, v), den, sat);
                r.out_z = scaled_quotient(row_sum(2, v), den, sat);
            end
        end
        else
        begin
            r.out_x = clamp32(row_sum(0, v), sat);
            r.out_y = clamp32(row_sum(1, v), sat);
            r.out_z = clamp32(row_sum(2, v), sat);
            if (vt4_pkg::kind_t'(t.kind) == vt4_pkg::KIND_FULL4)
                r.out_w = clamp32(row_sum(3, v), sat);
        end
        r.saturated = sat;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Result side: random stalls, each transaction checked against the oldest expectation.
    always @(posedge clk)
    begin
        vt4_pkg::vt4_out_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_vectors.size() == 0)
                    report_mismatch("unexpected result", 32'h0, 32'h0);
                else
                begin
                    want = pending_vectors.pop_front();
                    if (out_data.out_x !== want.out_x)
                        report_mismatch("out_x", out_data.out_x, want.out_x);
                    if (out_data.out_y !== want.out_y)
                        report_mismatch("out_y", out_data.out_y, want.out_y);
                    if (out_data.out_z !== want.out_z)
                        report_mismatch("out_z", out_data.out_z, want.out_z);
                    if (out_data.out_w !== want.out_w)
                        report_mismatch("out_w", out_data.out_w, want.out_w);
                    if (out_data.divide_by_zero !== want.divide_by_zero)
                        report_mismatch("divide_by_zero", 32'(out_data.divide_by_zero),
                                        32'(want.divide_by_zero));
                    if (out_data.saturated !== want.saturated)
                        report_mismatch("saturated", 32'(out_data.saturated),
                                        32'(want.saturated));
                end
            end
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Each write drops cfg_valid and waits again before returning, so consecutive writes do not collide in one step.
    task automatic write_coef(int idx, logic [63:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= vt4_pkg::CFG_IDX_W'(idx);
        cfg_value <= val;
        do @(posedge clk); while (!cfg_ready);
        matrix_regs[idx] = val;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_pipeline();
        in_valid <= 1'b0;
        while (pending_vectors.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    // The expectation is queued at the accepting edge, before the result can appear.
    // Valid stays high between back-to-back transactions and drops only while idling or draining.
    task automatic send_vector(vt4_pkg::vt4_in_t t, bit has_expect,
                               vt4_pkg::vt4_out_t typed_out);
        vt4_pkg::vt4_out_t want;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        want = has_expect ? typed_out : transform_vector(t);
        in_valid <= 1'b1;
        in_data <= t;
        do @(posedge clk); while (!in_ready);
        pending_vectors.push_back(want);
    endtask

    function automatic logic [31:0] random_component();
        case ($urandom_range(3))
            0: return $urandom();
            1: return 32'($urandom_range(262144)) - 32'd131072;
            2: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return 32'($urandom_range(8)) << 16;
        endcase
    endfunction

    function automatic logic [63:0] random_coef_pair();
        return {random_component(), random_component()};
    endfunction

    initial
    begin
        stim_row_t directed [$];
        stim_row_t row;
        vt4_pkg::vt4_in_t t;
        for (int i = 0; i < vt4_pkg::NUM_COEF_REGS; i++)
            matrix_regs[i] = vt4_pkg::COEF_RESET[i];
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // These fixed expectations assume that the reset matrix passes the inputs through unchanged.
        row.has_expect = 1'b1;
        row.vec = '{vt4_pkg::KIND_FULL4, 32'h7fffffff, 32'h80000000, 32'h00010000,
                    32'hffffffff};
        row.expect_out = '{32'h7fffffff, 32'h80000000, 32'h00010000, 32'hffffffff, 1'b0, 1'b0};
        directed.push_back(row);
        row.vec = '{vt4_pkg::KIND_AFFINE, 32'h80000000, 32'h7fffffff, 32'h0, 32'h12345678};
        row.expect_out = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 1'b0, 1'b0};
        directed.push_back(row);
        row.vec = '{vt4_pkg::KIND_ROT3, 32'hffffffff, 32'h1, 32'h80000000, 32'h7fffffff};
        row.expect_out = '{32'hffffffff, 32'h1, 32'h80000000, 32'h0, 1'b0, 1'b0};
        directed.push_back(row);
        row.vec = '{vt4_pkg::KIND_PROJ3, 32'h00030000, 32'hfffe0000, 32'h0, 32'h0};
        row.expect_out = '{32'h00030000, 32'hfffe0000, 32'h0, 32'h0, 1'b0, 1'b0};
        directed.push_back(row);
        row.has_expect = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            row.vec = '{vt4_pkg::kind_t'(k), 32'h7fffffff, 32'h7fffffff, 32'h80000000,
                        32'hffffffff};
            directed.push_back(row);
        end
        foreach (directed[i])
            send_vector(directed[i].vec, directed[i].has_expect, directed[i].expect_out);
        drain_pipeline();

        // Bottom two rows zeroed: a projective vector then has a zero w.
        write_coef(1, 64'h0);
        write_coef(3, 64'h0);
        write_coef(5, 64'h0);
        write_coef(7, 64'h0);
        row.has_expect = 1'b1;
        row.vec = '{vt4_pkg::KIND_PROJ3, 32'h00050000, 32'h7fffffff, 32'h80000000, 32'h1};
        row.expect_out = '{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0};
        send_vector(row.vec, 1'b1, row.expect_out);
        // Largest positive coefficients everywhere force saturation.
        drain_pipeline();
        for (int i = 0; i < vt4_pkg::NUM_COEF_REGS; i++)
            write_coef(i, 64'h7fffffff_7fffffff);
        for (int k = 0; k < 4; k++)
            send_vector('{vt4_pkg::kind_t'(k), 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff}, 1'b0, '0);
        drain_pipeline();
        for (int i = 0; i < vt4_pkg::NUM_COEF_REGS; i++)
            write_coef(i, 64'h80000000_80000000);
        for (int k = 0; k < 4; k++)
            send_vector('{vt4_pkg::kind_t'(k), 32'h7fffffff, 32'h80000000, 32'h1,
                          32'hffffffff}, 1'b0, '0);
        drain_pipeline();

        // Random part in idling phases, a fresh random matrix per phase but the last, which restores the reset matrix.
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
                default: begin send_idle_pct = 9; recv_stall_pct = 9; end
            endcase
            for (int i = 0; i < vt4_pkg::NUM_COEF_REGS; i++)
                write_coef(i, (phase == 7) ? vt4_pkg::COEF_RESET[i] : random_coef_pair());
            for (int n = 0; n < N_RANDOM / 8; n++)
            begin
                t.kind = 2'($urandom_range(3));
                t.vec_x = random_component();
                t.vec_y = random_component();
                t.vec_z = random_component();
                t.vec_w = random_component();
                send_vector(t, 1'b0, '0);
            end
            drain_pipeline();
        end

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

FILE: vertex_transform_4x4.f
rtl/vt4_pkg.sv
rtl/vertex_transform_4x4.sv
test/tb_vertex_transform_4x4.sv
